### rtl/rtcc_pkg.sv
// Package for the calendar day counter: item types, command codes and
// reset date. No dependencies.
package rtcc_pkg;

	localparam logic [1:0] CMD_TICK     = 2'd0;
	localparam logic [1:0] CMD_SET_TIME = 2'd1;
	localparam logic [1:0] CMD_SET_DATE = 2'd2;

	localparam logic [15:0] RESET_YEAR  = 16'd2012;
	localparam logic [3:0]  RESET_MONTH = 4'd1;
	localparam logic [4:0]  RESET_DAY   = 5'd1;

	// modular inverse of 25 mod 2^16 and the divisibility bound
	localparam logic [15:0] INV25     = 16'd23593;
	localparam logic [15:0] DIV25_MAX = 16'd2621;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [4:0]  hour_in;
		logic [5:0]  minute_in;
		logic [5:0]  second_in;
		logic [15:0] year_in;
		logic [3:0]  month_in;
		logic [4:0]  day_in;
	} req_t;

	typedef struct packed {
		logic [15:0] year_out;
		logic [3:0]  month_out;
		logic [4:0]  day_out;
		logic [4:0]  hour_out;
		logic [5:0]  minute_out;
		logic [5:0]  second_out;
		logic        date_rejected;
	} rsp_t;

endpackage

### rtl/rtc_calendar_day_counter.sv
// Calendar day counter top level: time-of-day and Gregorian date keeper.
// Depends on rtcc_pkg.
//
// Usage:
//   req channel (req_valid/req_ready/req) carries one command item: a
//   one-second tick, a set time (hour/minute/second) or a set date
//   (year/month/day). Code 3 leaves everything as it is.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns one item per command:
//   the date and H:M:S after the command, and date_rejected when a set
//   date named a day that does not exist (the stored date then stays).
//   An accepted item passes through the input register, then the result
//   register, which drives rsp_valid. Throughput: one item per cycle
//   while rsp is not held off; the whole update is one pass through the
//   counter and calendar logic between the two registers.
//   Time is held as hour/minute/second counters, so no
//   division is needed to report it.
//   Reset: time 00:00:00, date 2012-01-01, both stages empty.
//   Stall: when rsp is held off, the result register keeps its item and
//   one more item may sit in the input register; req_ready then drops.
module rtc_calendar_day_counter (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  rtcc_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output rtcc_pkg::rsp_t rsp
);
	import rtcc_pkg::*;

	function automatic logic leap_of(input logic [15:0] y);
		logic [15:0] p;
		logic        d4;
		logic        d16;
		logic        d25;
		p   = y * INV25;
		d4  = (y[1:0] == 2'd0);
		d16 = (y[3:0] == 4'd0);
		d25 = (p <= DIV25_MAX);
		return d4 && (!d25 || d16);
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] n;
		case (m)
			4'd2:                      n = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
			default:                   n = 5'd31;
		endcase
		return n;
	endfunction

	req_t        req_s1;
	logic        vld_s1;
	rsp_t        rsp_s2;
	logic        vld_s2;

	logic [5:0]  hour_q, minute_q, second_q;
	logic [15:0] year_q;
	logic [3:0]  month_q;
	logic [4:0]  day_q;

	logic [5:0]  hour_d, minute_d, second_d;
	logic [15:0] year_d;
	logic [3:0]  month_d;
	logic [4:0]  day_d;
	logic        rej_d;

	logic        adv_s2;
	logic        adv_s1;

	assign adv_s2    = !vld_s2 || rsp_ready;
	assign adv_s1    = vld_s1 && adv_s2;
	assign req_ready = !vld_s1 || adv_s2;
	assign rsp_valid = vld_s2;
	assign rsp       = rsp_s2;

	logic        wrap;
	logic [4:0]  cur_len;
	logic [4:0]  in_len;
	logic        s_c;
	logic [5:0]  s_norm;
	logic [6:0]  m_sum;
	logic        m_c;
	logic [6:0]  m_norm;
	logic        date_ok;

	always_comb begin
		wrap    = (hour_q >= 6'd24) ||
			(hour_q == 6'd23 && minute_q == 6'd59 && second_q == 6'd59);
		cur_len = month_len(month_q, leap_of(year_q));
		in_len  = month_len(req_s1.month_in, leap_of(req_s1.year_in));

		s_c    = (req_s1.second_in >= 6'd60);
		s_norm = s_c ? (req_s1.second_in - 6'd60) : req_s1.second_in;
		m_sum  = {1'b0, req_s1.minute_in} + {6'd0, s_c};
		m_c    = (m_sum >= 7'd60);
		m_norm = m_c ? (m_sum - 7'd60) : m_sum;

		date_ok = (req_s1.month_in >= 4'd1) && (req_s1.month_in <= 4'd12) &&
			(req_s1.day_in >= 5'd1) && (req_s1.day_in <= in_len);

		hour_d   = hour_q;
		minute_d = minute_q;
		second_d = second_q;
		year_d   = year_q;
		month_d  = month_q;
		day_d    = day_q;
		rej_d    = 1'b0;

		case (req_s1.cmd)
			CMD_TICK: begin
				if (wrap) begin
					hour_d   = 6'd0;
					minute_d = 6'd0;
					second_d = 6'd0;
					if (day_q < cur_len) begin
						day_d = day_q + 5'd1;
					end else if (month_q < 4'd12) begin
						month_d = month_q + 4'd1;
						day_d   = 5'd1;
					end else begin
						month_d = 4'd1;
						day_d   = 5'd1;
						year_d  = year_q + 16'd1;
					end
				end else if (second_q == 6'd59) begin
					second_d = 6'd0;
					if (minute_q == 6'd59) begin
						minute_d = 6'd0;
						hour_d   = hour_q + 6'd1;
					end else begin
						minute_d = minute_q + 6'd1;
					end
				end else begin
					second_d = second_q + 6'd1;
				end
			end
			CMD_SET_TIME: begin
				second_d = s_norm;
				minute_d = m_norm[5:0];
				hour_d   = {1'b0, req_s1.hour_in} + {5'd0, m_c};
			end
			CMD_SET_DATE: begin
				if (date_ok) begin
					year_d  = req_s1.year_in;
					month_d = req_s1.month_in;
					day_d   = req_s1.day_in;
				end else begin
					rej_d = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			hour_q   <= 6'd0;
			minute_q <= 6'd0;
			second_q <= 6'd0;
			year_q   <= RESET_YEAR;
			month_q  <= RESET_MONTH;
			day_q    <= RESET_DAY;
		end else begin
			if (req_ready) begin
				vld_s1 <= req_valid;
			end
			if (adv_s2) begin
				vld_s2 <= vld_s1;
			end
			if (adv_s1) begin
				hour_q   <= hour_d;
				minute_q <= minute_d;
				second_q <= second_d;
				year_q   <= year_d;
				month_q  <= month_d;
				day_q    <= day_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
		if (adv_s1) begin
			rsp_s2.year_out      <= year_d;
			rsp_s2.month_out     <= month_d;
			rsp_s2.day_out       <= day_d;
			rsp_s2.hour_out      <= hour_d[4:0];
			rsp_s2.minute_out    <= minute_d;
			rsp_s2.second_out    <= second_d;
			rsp_s2.date_rejected <= rej_d;
		end
	end

endmodule
